// ===== sv/dqr_pkg.sv =====
package dqr_pkg;

    // Buffer length cap; bytes consumed past it give no match
    localparam int unsigned MAX_BUFFER_LEN = 65535;
    localparam int unsigned LEN_CAP_INT    = (MAX_BUFFER_LEN < 65535) ? MAX_BUFFER_LEN : 65535;

    localparam int POS_W   = 16;
    localparam int OCT_W   = 9;
    localparam int PROD_W  = 12;
    localparam int PADDR_W = 3;

    localparam logic [POS_W-1:0] LEN_CAP = POS_W'(LEN_CAP_INT);

    // Character codes
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;

    // Octet limits
    localparam logic [OCT_W-1:0] OCT_MAX = 9'd255;
    localparam logic [OCT_W-1:0] OCT_SAT = 9'd256;
    localparam logic [1:0]       LAST_OCTET = 2'd3;

    // Register map (index = paddr[2])
    localparam logic REG_DETECT_MODE = 1'b0;

    // Detect modes
    localparam logic MODE_IPV4 = 1'b0;
    localparam logic MODE_INT  = 1'b1;

    // Result of one buffer
    typedef struct packed {
        logic             matched;
        logic [POS_W-1:0] match_length;
    } result_t;

endpackage

// ===== sv/dqr_regs.sv =====
module dqr_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dqr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic                        detect_mode
);

    logic mode_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == dqr_pkg::REG_DETECT_MODE);

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= dqr_pkg::MODE_IPV4;
        end
        else if (wr_en)
        begin
            mode_reg <= pwdata[0];
        end
    end

    // Read back
    always_comb
    begin
        if (paddr[2] == dqr_pkg::REG_DETECT_MODE)
        begin
            prdata = {31'b0, mode_reg};
        end
        else
        begin
            prdata = 32'b0;
        end
    end

    assign detect_mode = mode_reg;

endmodule

// ===== sv/dqr_scan.sv =====
module dqr_scan
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [7:0]       char_code,
    input  logic             last_char,
    input  logic             detect_mode,
    output logic             emit,
    output dqr_pkg::result_t result
);

    logic [1:0]                  octet_number_reg, octet_number_next;
    logic [dqr_pkg::OCT_W-1:0]   octet_value_reg, octet_value_next;
    logic                        digit_seen_reg, digit_seen_next;
    logic [dqr_pkg::POS_W-1:0]   char_position_reg, char_position_next;
    logic                        decided_reg, decided_next;

    logic                        dig;
    logic                        at_cap;
    logic                        oct_ok;
    logic                        fin_ok;
    logic                        ok;
    logic [dqr_pkg::POS_W-1:0]   len;
    logic [dqr_pkg::POS_W-1:0]   pos_inc;
    logic [dqr_pkg::PROD_W-1:0]  oct_prod;
    logic [dqr_pkg::OCT_W-1:0]   oct_acc;

    assign dig     = (char_code >= dqr_pkg::CHAR_ZERO) && (char_code <= dqr_pkg::CHAR_NINE);
    assign at_cap  = (char_position_reg >= dqr_pkg::LEN_CAP);
    assign pos_inc = char_position_reg + dqr_pkg::POS_W'(1);

    // Octet accumulate with saturation at 256
    assign oct_prod = dqr_pkg::PROD_W'(octet_value_reg) * dqr_pkg::PROD_W'(10)
                    + dqr_pkg::PROD_W'(char_code[3:0]);
    assign oct_acc  = (oct_prod > dqr_pkg::PROD_W'(dqr_pkg::OCT_SAT))
                    ? dqr_pkg::OCT_SAT : oct_prod[dqr_pkg::OCT_W-1:0];

    // Octet in range 1..255: before this byte, and after a final digit
    assign oct_ok = digit_seen_reg && (octet_value_reg != '0)
                  && (octet_value_reg <= dqr_pkg::OCT_MAX);
    assign fin_ok = (oct_acc != '0) && (oct_acc <= dqr_pkg::OCT_MAX);

    // Per-byte decision and next state
    always_comb
    begin
        octet_number_next  = octet_number_reg;
        octet_value_next   = octet_value_reg;
        digit_seen_next    = digit_seen_reg;
        char_position_next = char_position_reg;
        decided_next       = decided_reg;
        emit               = 1'b0;
        ok                 = 1'b0;
        len                = char_position_reg;

        if (fire && !decided_reg)
        begin
            if (detect_mode == dqr_pkg::MODE_INT)
            begin
                if (dig)
                begin
                    if (at_cap)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        char_position_next = pos_inc;
                        digit_seen_next    = 1'b1;
                        if (last_char)
                        begin
                            emit = 1'b1;
                            ok   = 1'b1;
                            len  = pos_inc;
                        end
                    end
                end
                else
                begin
                    emit = 1'b1;
                    ok   = digit_seen_reg;
                end
            end
            else
            begin
                if (dig)
                begin
                    if (at_cap)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        char_position_next = pos_inc;
                        octet_value_next   = oct_acc;
                        digit_seen_next    = 1'b1;
                        if (last_char)
                        begin
                            emit = 1'b1;
                            ok   = (octet_number_reg == dqr_pkg::LAST_OCTET) && fin_ok;
                            len  = pos_inc;
                        end
                    end
                end
                else if ((char_code == dqr_pkg::CHAR_DOT)
                         && (octet_number_reg != dqr_pkg::LAST_OCTET))
                begin
                    if (!oct_ok || at_cap || last_char)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        char_position_next = pos_inc;
                        octet_number_next  = octet_number_reg + 2'd1;
                        octet_value_next   = '0;
                        digit_seen_next    = 1'b0;
                    end
                end
                else
                begin
                    emit = 1'b1;
                    ok   = (octet_number_reg == dqr_pkg::LAST_OCTET) && oct_ok;
                end
            end
            if (emit)
            begin
                decided_next = 1'b1;
            end
        end

        // Final byte clears buffer state
        if (fire && last_char)
        begin
            octet_number_next  = '0;
            octet_value_next   = '0;
            digit_seen_next    = 1'b0;
            char_position_next = '0;
            decided_next       = 1'b0;
        end
    end

    assign result.matched      = ok;
    assign result.match_length = ok ? len : '0;

    // Buffer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octet_number_reg  <= '0;
            octet_value_reg   <= '0;
            digit_seen_reg    <= 1'b0;
            char_position_reg <= '0;
            decided_reg       <= 1'b0;
        end
        else
        begin
            octet_number_reg  <= octet_number_next;
            octet_value_reg   <= octet_value_next;
            digit_seen_reg    <= digit_seen_next;
            char_position_reg <= char_position_next;
            decided_reg       <= decided_next;
        end
    end

endmodule

// ===== sv/dqr_out.sv =====
module dqr_out
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  dqr_pkg::result_t          result,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic                      can_load,
    output logic                      matched,
    output logic [dqr_pkg::POS_W-1:0] match_length
);

    logic             valid_reg;
    dqr_pkg::result_t data_reg;

    assign can_load = !valid_reg || out_ready;

    // Result register: holds until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid    = valid_reg;
    assign matched      = data_reg.matched;
    assign match_length = data_reg.match_length;

endmodule

// ===== sv/ipv4_dotted_quad_recognizer_top.sv =====
// Dotted-quad / decimal-integer prefix recognizer.
// Input channel (in_valid/in_ready): one byte per transfer, char_code plus
// last_char marking the final byte of a buffer. Output channel
// (out_valid/out_ready): at most one result per buffer, matched and
// match_length, issued on the byte that settles the outcome; later bytes
// of that buffer produce nothing until last_char.
// APB register 0 (detect_mode): 0 = dotted IPv4, 1 = decimal integer run.
// Write it only while no buffer is in flight.
// A result is registered and appears in the cycle after the deciding byte is taken.
// Throughput: one byte per cycle while no pending result waits on out_ready; the
// per-byte update (octet multiply-add by ten and range check) sits between the
// state registers and the one-entry result register.
// Stall: while a result waits and out_ready is low, in_ready stays low for
// every byte; a byte is taken in the same cycle the pending result drains
// and may load the register again.
// Reset: clears mode to IPv4, buffer state, and the pending result.
module ipv4_dotted_quad_recognizer_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dqr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  char_code,
    input  logic                        last_char,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        matched,
    output logic [dqr_pkg::POS_W-1:0]   match_length
);

    logic             detect_mode;
    logic             fire;
    logic             emit;
    logic             can_load;
    dqr_pkg::result_t result;

    assign in_ready = can_load;
    assign fire     = in_valid && can_load;

    dqr_regs u_regs
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .detect_mode (detect_mode)
    );

    dqr_scan u_scan
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .char_code   (char_code),
        .last_char   (last_char),
        .detect_mode (detect_mode),
        .emit        (emit),
        .result      (result)
    );

    dqr_out u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (emit),
        .result       (result),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .can_load     (can_load),
        .matched      (matched),
        .match_length (match_length)
    );

endmodule

// ===== sv/dqr_checker.sv =====
module dqr_checker
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      matched,
    input logic [dqr_pkg::POS_W-1:0] match_length
);

    // Idle output side never blocks input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with no pending result");

    // No-match results carry zero length
    a_nomatch_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !matched |-> match_length == '0)
        else $error("nonzero length on no-match result");

    // A match consumes at least one byte
    a_match_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && matched |-> match_length != '0)
        else $error("zero length on match result");

    // Stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Stalled result payload holds
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(matched) && $stable(match_length))
        else $error("result changed while stalled");

endmodule

bind ipv4_dotted_quad_recognizer_top dqr_checker u_dqr_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .matched      (matched),
    .match_length (match_length)
);
